// ===== design/sccb_bit_master_unit_defines.svh =====
// Assertion macros used by the checker of the SCCB bit master.
`ifndef SCCB_BIT_MASTER_UNIT_DEFINES_SVH
`define SCCB_BIT_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbm check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbm check failed");

`endif

// ===== design/sbm_pkg.sv =====
// Types, constants and helper functions for the SCCB bit master.
package sbm_pkg;

  // Command codes as carried on req_type
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_NACK  = 3'd4
  } cmd_t;

  // One classified tick as it travels through the queue
  typedef struct packed {
    logic       has_cmd;
    cmd_t       cmd;
    logic [7:0] wdata;
    logic       pin;
  } tick_t;

  // One result word
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rdata;
  } res_t;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
  localparam logic [7:0]  MSB_MASK        = 8'h80;

  // Phase markers
  localparam logic [4:0] START_LAST  = 5'd3;
  localparam logic [4:0] STOP_LAST   = 5'd2;
  localparam logic [4:0] NACK_LAST   = 5'd3;
  localparam logic [4:0] WR_LAST     = 5'd27;
  localparam logic [4:0] RD_LAST     = 5'd24;
  localparam logic [4:0] WR_BITS_END = 5'd24;
  localparam logic [4:0] WR_RELEASE  = 5'd25;
  localparam logic [4:0] WR_ACK      = 5'd26;

  // Remainder by three of a 5-bit phase, via reciprocal multiply by 11/32
  function automatic logic [1:0] mod3(input logic [4:0] ph);
    logic [8:0] prod;
    logic [3:0] quo;
    logic [4:0] rem;
    prod = 9'(ph) * 9'd11;
    quo  = prod[8:5];
    rem  = ph - (5'(quo) * 5'd3);
    return rem[1:0];
  endfunction

  // Index of the final phase of each command
  function automatic logic [4:0] last_phase(input cmd_t cmd);
    logic [4:0] lp;
    unique case (cmd)
      CMD_START: lp = START_LAST;
      CMD_STOP:  lp = STOP_LAST;
      CMD_NACK:  lp = NACK_LAST;
      CMD_WRITE: lp = WR_LAST;
      CMD_READ:  lp = RD_LAST;
      default:   lp = RD_LAST;
    endcase
    return lp;
  endfunction

endpackage

// ===== design/sccb_bit_master_unit.sv =====
// Top level of the SCCB bit master: classifier, queue and line sequencer.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   cmd_valid req_type write_data sda_pin
//  out       output     out_valid / out_ready scl_level sda_level sda_drive busy_res
//                                             done_res ack_ok read_data
//  cfg       input      cfg_we                cfg_data (phase ticks)
//
// One tick word is taken per clock while the output is not stalled; each gives exactly one result word.
// A word passes the classifier register, then the queue, and the sequencer step
// that takes it from the queue writes its result into the output register.
// Reset (rst, synchronous) idles both lines high with the data driver on.
// A stalled output holds the sequencer; the queue and the classifier register
// then fill, and in_ready drops once they hold three words.
module sccb_bit_master_unit
  import sbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd_valid,
  input  logic [2:0]  req_type,
  input  logic [7:0]  write_data,
  input  logic        sda_pin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic        ack_ok,
  output logic [7:0]  read_data
);

  logic  push;
  tick_t push_tick;
  logic  q_full;
  logic  q_not_empty;
  tick_t q_tick;
  logic  pop;
  res_t  res;

  sbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd_valid  (cmd_valid),
    .req_type   (req_type),
    .write_data (write_data),
    .sda_pin    (sda_pin),
    .push       (push),
    .push_tick  (push_tick),
    .q_full     (q_full)
  );

  sbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tick (push_tick),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_tick  (q_tick)
  );

  sbm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_tick      (q_tick),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  assign scl_level = res.scl;
  assign sda_level = res.sda;
  assign sda_drive = res.drv;
  assign busy_res  = res.busy;
  assign done_res  = res.done;
  assign ack_ok    = res.ack;
  assign read_data = res.rdata;

endmodule

// ===== design/sbm_front.sv =====
// Input stage: takes ticks and classifies the offered command.
module sbm_front
  import sbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd_valid,
  input  logic [2:0] req_type,
  input  logic [7:0] write_data,
  input  logic       sda_pin,
  output logic       push,
  output tick_t      push_tick,
  input  logic       q_full
);

  logic  f_valid;
  tick_t f_tick;
  logic  take;

  assign push     = f_valid && !q_full;
  assign in_ready = !f_valid || !q_full;
  assign take     = in_valid && in_ready;
  assign push_tick = f_tick;

  // Hold the staged word valid until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // Classify: drop undefined codes to a plain tick
  always_ff @(posedge clk) begin
    if (take) begin
      f_tick.has_cmd <= cmd_valid && (req_type <= 3'(CMD_NACK));
      f_tick.cmd     <= cmd_t'(req_type);
      f_tick.wdata   <= write_data;
      f_tick.pin     <= sda_pin;
    end
  end

endmodule

// ===== design/sbm_queue.sv =====
// Two-entry queue between the classifier and the line sequencer.
module sbm_queue
  import sbm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  tick_t push_tick,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output tick_t pop_tick
);

  tick_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_tick  = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tick;
    end
  end

endmodule

// ===== design/sbm_back.sv =====
// Line sequencer: steps one tick per queued word and registers the result.
module sbm_back
  import sbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        q_not_empty,
  input  tick_t       q_tick,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        res
);

  logic [15:0] phase_ticks;
  logic        busy,   busy_next;
  cmd_t        cmd,    cmd_next;
  logic [4:0]  ph,     ph_next;
  logic [15:0] tc,     tc_next;
  logic [7:0]  shift,  shift_next;
  logic        scl,    scl_next;
  logic        sda,    sda_next;
  logic        drv,    drv_next;
  logic        ack,    ack_next;
  logic [7:0]  rbyte,  rbyte_next;
  logic        done;
  logic [15:0] hold;
  logic        do_apply;
  cmd_t        a_cmd;
  logic [4:0]  a_ph;
  logic [1:0]  r;

  assign pop  = q_not_empty && (!out_valid || out_ready);
  assign hold = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  // Work out the state after one tick
  always_comb begin
    busy_next  = busy;
    cmd_next   = cmd;
    ph_next    = ph;
    tc_next    = tc;
    shift_next = shift;
    scl_next   = scl;
    sda_next   = sda;
    drv_next   = drv;
    ack_next   = ack;
    rbyte_next = rbyte;
    done       = 1'b0;
    do_apply   = 1'b0;
    a_cmd      = q_tick.cmd;
    a_ph       = 5'd0;
    r          = 2'd0;

    if (!busy) begin
      // Start a command from idle
      if (q_tick.has_cmd) begin
        busy_next = 1'b1;
        cmd_next  = q_tick.cmd;
        ph_next   = 5'd0;
        tc_next   = 16'd1;
        if (q_tick.cmd == CMD_WRITE) begin
          shift_next = q_tick.wdata;
        end else if (q_tick.cmd == CMD_READ) begin
          shift_next = 8'd0;
        end
        if (q_tick.cmd != CMD_READ) begin
          drv_next = 1'b1;
        end
        do_apply = 1'b1;
        a_cmd    = q_tick.cmd;
        a_ph     = 5'd0;
      end
    end else if (tc < hold) begin
      tc_next = tc + 16'd1;
    end else begin
      // Close the current phase: sample ack or data, or retake the data line
      if (cmd == CMD_WRITE) begin
        if (ph == WR_ACK) begin
          ack_next = !q_tick.pin;
        end else if (ph == WR_LAST) begin
          drv_next = 1'b1;
        end
      end else if (cmd == CMD_READ && ph != 5'd0) begin
        if (mod3(ph - 5'd1) == 2'd1) begin
          shift_next = {shift[6:0], q_tick.pin};
        end
      end
      if (ph >= last_phase(cmd)) begin
        if (cmd == CMD_READ) begin
          rbyte_next = shift_next;
        end
        busy_next = 1'b0;
        ph_next   = 5'd0;
        tc_next   = 16'd0;
        done      = 1'b1;
      end else begin
        ph_next  = ph + 5'd1;
        tc_next  = 16'd1;
        do_apply = 1'b1;
        a_cmd    = cmd;
        a_ph     = ph + 5'd1;
      end
    end

    // Apply the line action that opens a phase
    if (do_apply) begin
      unique case (a_cmd)
        CMD_START: begin
          if (a_ph == 5'd0)      sda_next = 1'b1;
          else if (a_ph == 5'd1) scl_next = 1'b1;
          else if (a_ph == 5'd2) sda_next = 1'b0;
          else                   scl_next = 1'b0;
        end
        CMD_STOP: begin
          if (a_ph == 5'd0)      sda_next = 1'b0;
          else if (a_ph == 5'd1) scl_next = 1'b1;
          else                   sda_next = 1'b1;
        end
        CMD_NACK: begin
          if (a_ph == 5'd0)      sda_next = 1'b1;
          else if (a_ph == 5'd1) scl_next = 1'b1;
          else if (a_ph == 5'd2) scl_next = 1'b0;
          else                   sda_next = 1'b0;
        end
        CMD_WRITE: begin
          if (a_ph < WR_BITS_END) begin
            r = mod3(a_ph);
            if (r == 2'd0) begin
              sda_next   = |(shift_next & MSB_MASK);
              shift_next = {shift_next[6:0], 1'b0};
            end else if (r == 2'd1) begin
              scl_next = 1'b1;
            end else begin
              scl_next = 1'b0;
            end
          end else if (a_ph == WR_RELEASE) begin
            drv_next = 1'b0;
          end else if (a_ph == WR_ACK) begin
            scl_next = 1'b1;
          end else if (a_ph == WR_LAST) begin
            scl_next = 1'b0;
          end
        end
        CMD_READ: begin
          if (a_ph == 5'd0) begin
            drv_next = 1'b0;
          end else begin
            r = mod3(a_ph - 5'd1);
            if (r == 2'd1)      scl_next = 1'b1;
            else if (r == 2'd2) scl_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      phase_ticks <= cfg_data;
    end
  end

  // Advance the sequencer once per queued word
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cmd   <= CMD_START;
      ph    <= 5'd0;
      tc    <= 16'd0;
      shift <= 8'd0;
      scl   <= 1'b1;
      sda   <= 1'b1;
      drv   <= 1'b1;
      ack   <= 1'b0;
      rbyte <= 8'd0;
    end else if (pop) begin
      busy  <= busy_next;
      cmd   <= cmd_next;
      ph    <= ph_next;
      tc    <= tc_next;
      shift <= shift_next;
      scl   <= scl_next;
      sda   <= sda_next;
      drv   <= drv_next;
      ack   <= ack_next;
      rbyte <= rbyte_next;
    end
  end

  // Output register: fill on a step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.scl   <= scl_next;
      res.sda   <= drv_next ? sda_next : 1'b1;
      res.drv   <= drv_next;
      res.busy  <= busy_next;
      res.done  <= done;
      res.ack   <= ack_next;
      res.rdata <= rbyte_next;
    end
  end

endmodule

// ===== design/sbm_checker.sv =====
// Port-level checks for the SCCB bit master, bound to the top level.
`include "sccb_bit_master_unit_defines.svh"

module sbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        scl_level,
  input logic        sda_level,
  input logic        sda_drive,
  input logic        busy_res,
  input logic        done_res,
  input logic        ack_ok,
  input logic [7:0]  read_data
);

  logic [13:0] out_word;

  assign out_word = {scl_level, sda_level, sda_drive, busy_res, done_res, ack_ok, read_data};

  // A stalled result word holds
  `SBM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // A finishing command leaves the sequencer idle
  `SBM_ASSERT_NOW(a_done_idle, clk, rst, out_valid && done_res, !busy_res)

  // A released data line reads high
  `SBM_ASSERT_NOW(a_release_high, clk, rst, out_valid && !sda_drive, sda_level)

  // The input only backs up behind a waiting result word
  `SBM_ASSERT_NOW(a_stall_behind_out, clk, rst, !in_ready, out_valid)

endmodule

bind sccb_bit_master_unit sbm_checker u_sbm_checker (.*);

// ===== test/tb_sccb_bit_master_unit.sv =====
// Self-checking testbench for the SCCB bit master: directed tick table, then bus transactions.
module tb_sccb_bit_master_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sbm_pkg::*;

  // Longest quiet stretch: the long hold-off plus the drain pause, several times over
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 300;
  localparam int NO_CFG         = -1;
  localparam int PCT_NONE       = 0;
  localparam int PCT_HEAVY      = 53;
  localparam int PCT_LIGHT      = 11;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam res_t LINES_IDLE = '{scl: 1'b1, sda: 1'b1, drv: 1'b1, busy: 1'b0,
                                  done: 1'b0, ack: 1'b0, rdata: 8'h00};
  localparam res_t START_OPEN = '{scl: 1'b1, sda: 1'b1, drv: 1'b1, busy: 1'b1,
                                  done: 1'b0, ack: 1'b0, rdata: 8'h00};

  typedef struct {
    int         set_ticks;
    logic       valid;
    logic [2:0] req;
    logic [7:0] wdata;
    logic       pin;
    int         reps;
    logic       typed;
    res_t       want;
  } plan_row_t;

  typedef struct {
    logic [15:0] ticks;
    int          send_pct;
    int          stall_pct;
    logic        long_hold;
    int          count;
  } run_phase_t;

  typedef struct packed {
    cmd_t       c;
    logic [7:0] b;
  } bus_op_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        cmd_valid  = 1'b0;
  logic [2:0]  req_type   = '0;
  logic [7:0]  write_data = '0;
  logic        sda_pin    = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        scl_level, sda_level, sda_drive, busy_res, done_res, ack_ok;
  logic [7:0]  read_data;
  res_t        line_seen;

  assign line_seen = {scl_level, sda_level, sda_drive, busy_res, done_res, ack_ok, read_data};

  always #2 clk = ~clk;

  sccb_bit_master_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd_valid  (cmd_valid),
    .req_type   (req_type),
    .write_data (write_data),
    .sda_pin    (sda_pin),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_drive  (sda_drive),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .ack_ok     (ack_ok),
    .read_data  (read_data)
  );

  // Line sequencer as the testbench sees it
  logic [15:0] ln_ticks = PHASE_TICKS_RST;
  logic        ln_busy  = 1'b0;
  cmd_t        ln_cmd   = CMD_START;
  logic [4:0]  ln_phase = '0;
  logic [15:0] ln_count = '0;
  logic [7:0]  ln_shift = '0;
  logic        ln_scl   = 1'b1;
  logic        ln_sda   = 1'b1;
  logic        ln_drv   = 1'b1;
  logic        ln_ack   = 1'b0;
  logic [7:0]  ln_rbyte = '0;

  res_t    line_expect [$];
  bus_op_t txn_ops [$];
  int      cmd_counts [5] = '{default: 0};
  int      sender_pct   = PCT_NONE;
  int      stall_pct    = PCT_NONE;
  logic    hold_request = 1'b0;
  int      hold_left    = 0;
  int      mismatches   = 0;
  int      ticks_sent   = 0;
  int      words_seen   = 0;
  int      cfg_writes   = 0;
  int      quiet_cycles = 0;

  plan_row_t directed_rows [20] = '{
    '{NO_CFG, 1'b0, CMD_START, 8'h00, 1'b0, 0,      1'b1, LINES_IDLE},
    '{NO_CFG, 1'b1, REQ_RSVD7, 8'hFF, 1'b1, 0,      1'b1, LINES_IDLE},
    '{NO_CFG, 1'b1, REQ_RSVD5, 8'h5A, 1'b0, 0,      1'b1, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_START, 8'h00, 1'b0, 40,     1'b1, START_OPEN},
    '{1,      1'b0, CMD_START, 8'h00, 1'b0, 0,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_WRITE, 8'hFF, 1'b0, 28,     1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_WRITE, 8'h00, 1'b1, 28,     1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_WRITE, 8'hA5, 1'b0, 28,     1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_READ,  8'h00, 1'b1, 25,     1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_READ,  8'hFF, 1'b0, 25,     1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_NACK,  8'h00, 1'b1, 4,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_STOP,  8'h00, 1'b0, 3,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_START, 8'h00, 1'b1, 2,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_WRITE, 8'h81, 1'b0, 0,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_READ,  8'h00, 1'b1, 0,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_READ,  8'h00, 1'b1, 25,     1'b0, LINES_IDLE},
    '{0,      1'b0, CMD_START, 8'h00, 1'b0, 0,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b1, CMD_WRITE, 8'h3C, 1'b0, 28,     1'b0, LINES_IDLE},
    '{65535,  1'b0, CMD_START, 8'h00, 1'b0, 0,      1'b0, LINES_IDLE},
    '{NO_CFG, 1'b0, CMD_STOP,  8'h00, 1'b1, 4,      1'b0, LINES_IDLE}
  };

  run_phase_t random_phases [6] = '{
    '{16'd1, PCT_NONE,  PCT_NONE,  1'b0, 80},
    '{16'd2, PCT_HEAVY, PCT_NONE,  1'b0, 70},
    '{16'd1, PCT_NONE,  PCT_HEAVY, 1'b0, 80},
    '{16'd3, PCT_LIGHT, PCT_LIGHT, 1'b0, 60},
    '{16'd1, PCT_NONE,  PCT_NONE,  1'b1, 60},
    '{16'd1, PCT_LIGHT, PCT_LIGHT, 1'b0, 50}
  };

  // Apply the line action that opens a phase
  function automatic void open_phase(input logic [4:0] ph);
    logic [4:0] r;
    r = (ln_cmd == CMD_READ) ? ((ph - 5'd1) % 5'd3) : (ph % 5'd3);
    case (ln_cmd)
      CMD_START: begin
        if (ph == 5'd0) ln_sda = 1'b1;
        else if (ph == 5'd1) ln_scl = 1'b1;
        else if (ph == 5'd2) ln_sda = 1'b0;
        else ln_scl = 1'b0;
      end
      CMD_STOP: begin
        if (ph == 5'd0) ln_sda = 1'b0;
        else if (ph == 5'd1) ln_scl = 1'b1;
        else ln_sda = 1'b1;
      end
      CMD_NACK: begin
        if (ph == 5'd0) ln_sda = 1'b1;
        else if (ph == 5'd1) ln_scl = 1'b1;
        else if (ph == 5'd2) ln_scl = 1'b0;
        else ln_sda = 1'b0;
      end
      CMD_WRITE: begin
        if (ph < WR_BITS_END) begin
          if (r == 5'd0) begin
            ln_sda   = (ln_shift & MSB_MASK) != 8'h00;
            ln_shift = {ln_shift[6:0], 1'b0};
          end else if (r == 5'd1) begin
            ln_scl = 1'b1;
          end else begin
            ln_scl = 1'b0;
          end
        end else if (ph == WR_RELEASE) begin
          ln_drv = 1'b0;
        end else if (ph == WR_ACK) begin
          ln_scl = 1'b1;
        end else if (ph == WR_LAST) begin
          ln_scl = 1'b0;
        end
      end
      default: begin
        if (ph == 5'd0) ln_drv = 1'b0;
        else if (r == 5'd1) ln_scl = 1'b1;
        else if (r == 5'd2) ln_scl = 1'b0;
      end
    endcase
  endfunction

  // Sample the data line, or retake it, as a phase runs out
  function automatic void close_phase(input logic [4:0] ph, input logic pin);
    if (ln_cmd == CMD_WRITE) begin
      if (ph == WR_ACK) ln_ack = ~pin;
      else if (ph == WR_LAST) ln_drv = 1'b1;
    end else if (ln_cmd == CMD_READ && ph != 5'd0 && ((ph - 5'd1) % 5'd3) == 5'd1) begin
      ln_shift = {ln_shift[6:0], pin};
    end
  endfunction

  // Advance the sequencer by one tick and return the line word it shows
  function automatic res_t line_tick(input logic v, input logic [2:0] req,
                                     input logic [7:0] wd, input logic pin);
    logic [15:0] hold;
    logic [4:0]  last;
    logic        done;
    res_t        r;
    hold = (ln_ticks == 16'd0) ? 16'd1 : ln_ticks;
    done = 1'b0;
    if (!ln_busy) begin
      if (v && req <= CMD_NACK) begin
        ln_busy  = 1'b1;
        ln_cmd   = cmd_t'(req);
        ln_phase = 5'd0;
        ln_count = 16'd1;
        cmd_counts[int'(ln_cmd)]++;
        if (ln_cmd == CMD_WRITE) ln_shift = wd;
        else if (ln_cmd == CMD_READ) ln_shift = 8'h00;
        if (ln_cmd != CMD_READ) ln_drv = 1'b1;
        open_phase(5'd0);
      end
    end else if (ln_count < hold) begin
      ln_count++;
    end else begin
      close_phase(ln_phase, pin);
      case (ln_cmd)
        CMD_START: last = START_LAST;
        CMD_STOP:  last = STOP_LAST;
        CMD_NACK:  last = NACK_LAST;
        CMD_WRITE: last = WR_LAST;
        default:   last = RD_LAST;
      endcase
      if (ln_phase >= last) begin
        if (ln_cmd == CMD_READ) ln_rbyte = ln_shift;
        ln_busy  = 1'b0;
        ln_phase = 5'd0;
        ln_count = 16'd0;
        done     = 1'b1;
      end else begin
        ln_phase++;
        ln_count = 16'd1;
        open_phase(ln_phase);
      end
    end
    r.scl   = ln_scl;
    r.sda   = ln_drv ? ln_sda : 1'b1;
    r.drv   = ln_drv;
    r.busy  = ln_busy;
    r.done  = done;
    r.ack   = ln_ack;
    r.rdata = ln_rbyte;
    return r;
  endfunction

  // Offer one tick word, hold it until taken, then log what it should produce
  task automatic send_tick(input logic v, input logic [2:0] req, input logic [7:0] wd,
                           input logic pin, input logic typed, input res_t want);
    res_t pred;
    while (sender_pct != PCT_NONE && $urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd_valid  <= v;
    req_type   <= req;
    write_data <= wd;
    sda_pin    <= pin;
    do @(posedge clk); while (!in_ready);
    pred = line_tick(v, req, wd, pin);
    line_expect.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // Drop valid and hold until every expected word is back
  task automatic wait_results();
    in_valid <= 1'b0;
    while (line_expect.size() != 0) @(posedge clk);
  endtask

  // Run the sequencer down to idle, drain the output, then write the phase length
  task automatic write_phase_ticks(input logic [15:0] v);
    while (ln_busy) send_tick(1'b0, CMD_START, 8'h00, 1'($urandom_range(1)), 1'b0, LINES_IDLE);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ln_ticks = v;
    cfg_writes++;
  endtask

  // Queue one register access: start, device and register address, then a write or a read, and a stop
  task automatic plan_transaction();
    logic [7:0] dev;
    dev    = 8'($urandom);
    dev[0] = 1'b0;
    txn_ops.push_back('{c: CMD_START, b: 8'h00});
    txn_ops.push_back('{c: CMD_WRITE, b: dev});
    txn_ops.push_back('{c: CMD_WRITE, b: 8'($urandom)});
    if ($urandom_range(1) == 0) begin
      txn_ops.push_back('{c: CMD_WRITE, b: 8'($urandom)});
    end else begin
      txn_ops.push_back('{c: CMD_START, b: 8'h00});
      txn_ops.push_back('{c: CMD_WRITE, b: dev | 8'h01});
      txn_ops.push_back('{c: CMD_READ,  b: 8'($urandom)});
      txn_ops.push_back('{c: CMD_NACK,  b: 8'h00});
    end
    txn_ops.push_back('{c: CMD_STOP, b: 8'h00});
  endtask

  // Mostly the next bus step while idle; noise commands otherwise
  task automatic offer_random_tick();
    bus_op_t    op;
    logic       v;
    logic [2:0] req;
    logic [7:0] wd;
    v   = ($urandom_range(99) < 30);
    req = 3'($urandom_range(7));
    wd  = 8'($urandom);
    if (!ln_busy && $urandom_range(99) < 85) begin
      if (txn_ops.size() == 0) plan_transaction();
      op  = txn_ops.pop_front();
      v   = 1'b1;
      req = op.c;
      wd  = op.b;
    end
    send_tick(v, req, wd, 1'($urandom_range(1)), 1'b0, LINES_IDLE);
  endtask

  // Check one result word against the oldest expectation
  task automatic compare_lines(input res_t got);
    res_t want;
    words_seen++;
    if (line_expect.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: result word %0d arrived with nothing expected: %p", words_seen, got);
    end else begin
      want = line_expect.pop_front();
      if (got.scl !== want.scl || got.sda !== want.sda || got.drv !== want.drv ||
          got.busy !== want.busy || got.done !== want.done || got.ack !== want.ack ||
          got.rdata !== want.rdata) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: word %0d expected scl=%b sda=%b drv=%b busy=%b done=%b ack=%b rd=%h",
                   words_seen, want.scl, want.sda, want.drv, want.busy, want.done, want.ack,
                   want.rdata);
          $display("       got      scl=%b sda=%b drv=%b busy=%b done=%b ack=%b rd=%h",
                   got.scl, got.sda, got.drv, got.busy, got.done, got.ack, got.rdata);
        end
      end
    end
  endtask

  // Take result words and pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) compare_lines(line_seen);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Abort when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table with no idling
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_ticks != NO_CFG) begin
        write_phase_ticks(16'(directed_rows[i].set_ticks));
      end else begin
        send_tick(directed_rows[i].valid, directed_rows[i].req, directed_rows[i].wdata,
                  directed_rows[i].pin, directed_rows[i].typed, directed_rows[i].want);
        repeat (directed_rows[i].reps)
          send_tick(1'b0, directed_rows[i].req, directed_rows[i].wdata,
                    directed_rows[i].pin, 1'b0, LINES_IDLE);
      end
    end

    // Random bus traffic over several phase lengths and idling mixes
    foreach (random_phases[p]) begin
      write_phase_ticks(random_phases[p].ticks);
      sender_pct = random_phases[p].send_pct;
      stall_pct  = random_phases[p].stall_pct;
      for (int k = 0; k < random_phases[p].count; k++) begin
        if (random_phases[p].long_hold && k == 10) hold_request = 1'b1;
        if (k == random_phases[p].count / 2) wait_results();
        offer_random_tick();
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    $display("Covered %0d ticks, %0d result words, %0d phase-length writes.",
             ticks_sent, words_seen, cfg_writes);
    $display("Commands run: start %0d, stop %0d, write %0d, read %0d, no-ack %0d; %0d mismatches.",
             cmd_counts[CMD_START], cmd_counts[CMD_STOP], cmd_counts[CMD_WRITE],
             cmd_counts[CMD_READ], cmd_counts[CMD_NACK], mismatches);
    if (mismatches == 0 && line_expect.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
